// File: sv/eto_pkg.sv
// types and constants shared by the event timeline sort and merge block
`default_nettype none
package eto_pkg;

	localparam int KEY_W   = 32;
	localparam int LEN_W   = 20;
	localparam int SPM_W   = 16;
	localparam int OFS_W   = 20;
	localparam int ENT_W   = 23;
	localparam int FLAG_W  = 3;
	localparam int PIECE_W = 16;
	localparam int BASE_W  = 37;
	localparam int POS_W   = 39;
	localparam int HALF_W  = 19;
	localparam int PROD_W  = HALF_W + SPM_W;
	localparam int SUM_W   = 55;
	localparam int RECIPE_MAX = 3;
	localparam int ENTRY_IDX_W = 2;
	localparam int IDX_W   = 3;

	localparam logic [SPM_W-1:0] SPM_RESET = 16'd256;
	localparam logic [ENT_W-1:0] RECIPE0_RESET = 23'd681986;
	localparam logic [ENT_W-1:0] RECIPE1_RESET = 23'd1560578;
	localparam logic [ENT_W-1:0] RECIPE2_RESET = 23'd2242564;
	localparam logic [SUM_W-1:0] ROUND_HALF = 55'd32768;

	typedef enum logic [IDX_W-1:0] {
		REG_PIECE_LENGTH = 3'd0,
		REG_STEPS_PER_MM = 3'd1,
		REG_PIERCE_OFS   = 3'd2,
		REG_SLIT_OFS     = 3'd3,
		REG_CUT_OFS      = 3'd4,
		REG_RECIPE0      = 3'd5,
		REG_RECIPE1      = 3'd6,
		REG_RECIPE2      = 3'd7
	} eto_reg_e;

	typedef struct packed {
		logic [LEN_W-1:0] piece_length;
		logic [SPM_W-1:0] steps_per_mm;
		logic [OFS_W-1:0] pierce_ofs;
		logic [OFS_W-1:0] slit_ofs;
		logic [OFS_W-1:0] cut_ofs;
		logic [ENT_W-1:0] recipe0;
		logic [ENT_W-1:0] recipe1;
		logic [ENT_W-1:0] recipe2;
	} eto_cfg_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [FLAG_W-1:0] flags;
	} eto_slot_t;

	typedef struct packed {
		logic              ins;
		logic              pop;
		logic              any_eq;
		logic [KEY_W-1:0]  key;
		logic [FLAG_W-1:0] flags;
	} eto_ctrl_t;

endpackage
`default_nettype wire

// File: sv/eto_cell.sv
// one cell of the sorted insertion chain with duplicate merge
`default_nettype none
module eto_cell
	import eto_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire eto_ctrl_t ctrl,
	input  wire logic      prev_gt,
	input  wire eto_slot_t prev_slot,
	input  wire eto_slot_t next_slot,
	output eto_slot_t      slot,
	output logic           gt,
	output logic           eq
);

	logic              valid_q;
	logic [KEY_W-1:0]  key_q;
	logic [FLAG_W-1:0] flags_q;
	logic              valid_d;
	logic [KEY_W-1:0]  key_d;
	logic [FLAG_W-1:0] flags_d;

	assign gt = !valid_q || (key_q > ctrl.key);
	assign eq = valid_q && (key_q == ctrl.key);
	assign slot = '{valid: valid_q, key: key_q, flags: flags_q};

	always_comb begin
		valid_d = valid_q;
		key_d   = key_q;
		flags_d = flags_q;
		priority if (ctrl.pop) begin
			valid_d = next_slot.valid;
			key_d   = next_slot.key;
			flags_d = next_slot.flags;
		end else if (ctrl.ins && ctrl.any_eq) begin
			if (eq) begin
				flags_d = flags_q | ctrl.flags;
			end
		end else if (ctrl.ins && prev_gt) begin
			valid_d = prev_slot.valid;
			key_d   = prev_slot.key;
			flags_d = prev_slot.flags;
		end else if (ctrl.ins && gt) begin
			valid_d = 1'b1;
			key_d   = ctrl.key;
			flags_d = ctrl.flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q   <= key_d;
		flags_q <= flags_d;
	end

endmodule
`default_nettype wire

// File: sv/eto_gen.sv
// event generator: window sequencer and step position pipeline
`default_nettype none
module eto_gen
	import eto_pkg::*;
#(
	parameter int WINDOW_BEFORE  = 5,
	parameter int WINDOW_AFTER   = 15,
	parameter int RECIPE_SIZE    = 3,
	parameter int EVENT_CAPACITY = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [PIECE_W-1:0] start_piece,
	input  wire eto_cfg_t           cfg,
	output eto_slot_t               evt,
	output logic                    idle
);

	localparam int PW = $clog2(WINDOW_BEFORE + WINDOW_AFTER + 1);
	localparam int CW = $clog2(EVENT_CAPACITY + 1);

	logic                   active_q;
	logic [BASE_W-1:0]      base_q;
	logic [PW-1:0]          left_q;
	logic [ENTRY_IDX_W-1:0] entry_q;
	logic [CW-1:0]          cnt_q;

	logic [PIECE_W-1:0]     first;
	logic [PW-1:0]          pieces;
	logic [ENT_W-1:0]       recipe [RECIPE_MAX];
	logic [ENT_W-1:0]       entry;
	logic [OFS_W-1:0]       tool;
	logic                   last_entry;
	logic [POS_W-1:0]       pos;

	logic                   v_s1, v_s2, v_s3;
	logic [POS_W-1:0]       pos_s1;
	logic [FLAG_W-1:0]      flags_s1, flags_s2, flags_s3;
	logic                   neg_s2;
	logic [PROD_W-1:0]      lo_s2, hi_s2;
	logic [KEY_W-1:0]       key_s3;
	logic [SUM_W-1:0]       sum;
	logic [POS_W-1:0]       steps;

	assign recipe[0] = cfg.recipe0;
	assign recipe[1] = cfg.recipe1;
	assign recipe[2] = cfg.recipe2;

	always_comb begin
		if (start_piece >= PIECE_W'(WINDOW_BEFORE)) begin
			first  = start_piece - PIECE_W'(WINDOW_BEFORE);
			pieces = PW'(WINDOW_BEFORE + WINDOW_AFTER);
		end else begin
			first  = '0;
			pieces = PW'(start_piece) + PW'(WINDOW_AFTER);
		end
	end

	assign entry      = recipe[entry_q];
	assign last_entry = (entry_q == ENTRY_IDX_W'(RECIPE_SIZE - 1));

	always_comb begin
		priority if (entry[0]) begin
			tool = cfg.pierce_ofs;
		end else if (entry[1]) begin
			tool = cfg.slit_ofs;
		end else if (entry[2]) begin
			tool = cfg.cut_ofs;
		end else begin
			tool = '0;
		end
	end

	assign pos = {{(POS_W-BASE_W){1'b0}}, base_q}
		+ {{(POS_W-OFS_W){tool[OFS_W-1]}}, tool}
		+ {{(POS_W-(ENT_W-FLAG_W)){1'b0}}, entry[ENT_W-1:FLAG_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			left_q   <= '0;
			entry_q  <= '0;
			cnt_q    <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			left_q   <= pieces;
			entry_q  <= '0;
			cnt_q    <= '0;
		end else if (active_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_entry) begin
				entry_q <= '0;
				left_q  <= left_q - 1'b1;
			end else begin
				entry_q <= entry_q + 1'b1;
			end
			if ((last_entry && left_q == PW'(1)) || cnt_q == CW'(EVENT_CAPACITY - 1)) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			base_q <= BASE_W'(first * cfg.piece_length);
		end else if (active_q && last_entry) begin
			base_q <= base_q + BASE_W'(cfg.piece_length);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= active_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign sum = {hi_s2, {HALF_W{1'b0}}} + SUM_W'(lo_s2) + ROUND_HALF;
	assign steps = sum[SUM_W-1:SUM_W-POS_W];

	always_ff @(posedge clk) begin
		pos_s1   <= pos;
		flags_s1 <= entry[FLAG_W-1:0];
		neg_s2   <= pos_s1[POS_W-1];
		lo_s2    <= pos_s1[HALF_W-1:0] * cfg.steps_per_mm;
		hi_s2    <= pos_s1[2*HALF_W-1:HALF_W] * cfg.steps_per_mm;
		flags_s2 <= flags_s1;
		flags_s3 <= flags_s2;
		if (neg_s2) begin
			key_s3 <= '0;
		end else if (|steps[POS_W-1:KEY_W]) begin
			key_s3 <= '1;
		end else begin
			key_s3 <= steps[KEY_W-1:0];
		end
	end

	assign evt  = '{valid: v_s3, key: key_s3, flags: flags_s3};
	assign idle = !active_q && !v_s1 && !v_s2 && !v_s3;

endmodule
`default_nettype wire

// File: sv/event_timeline_sort_merge.sv
// top level: config registers, event generator and sorting cell chain
// order: the first result follows the input transfer once all N raw events
// (window pieces times recipe entries, capped at EVENT_CAPACITY), one per cycle, have left the generator
// pipeline; M merged results then drain one per cycle while out_stall is low, and no new input is taken
// until the last is out; the cell chain inserts one event per cycle and shifts one result out per transfer
// reset: registers take their reset values, chain empty, input open
`default_nettype none
module event_timeline_sort_merge
	import eto_pkg::*;
#(
	parameter int WINDOW_BEFORE  = 5,
	parameter int WINDOW_AFTER   = 15,
	parameter int RECIPE_SIZE    = 3,
	parameter int EVENT_CAPACITY = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [IDX_W-1:0]   cfg_index,
	input  wire logic [ENT_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [PIECE_W-1:0] start_piece,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [KEY_W-1:0]        position_steps,
	output logic                    pierce,
	output logic                    slit,
	output logic                    cut,
	output logic                    last
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t    state_q;
	eto_cfg_t  cfg_q;
	logic      accept;
	logic      pop;
	logic      gen_idle;
	eto_slot_t evt;
	eto_ctrl_t ctrl;

	eto_slot_t               slot [EVENT_CAPACITY + 2];
	logic [EVENT_CAPACITY-1:0] gt_vec;
	logic [EVENT_CAPACITY-1:0] eq_vec;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{piece_length: '0, steps_per_mm: SPM_RESET, pierce_ofs: '0,
				slit_ofs: '0, cut_ofs: '0, recipe0: RECIPE0_RESET,
				recipe1: RECIPE1_RESET, recipe2: RECIPE2_RESET};
		end else if (cfg_valid && cfg_ready) begin
			unique case (eto_reg_e'(cfg_index))
				REG_PIECE_LENGTH: cfg_q.piece_length <= cfg_data[LEN_W-1:0];
				REG_STEPS_PER_MM: cfg_q.steps_per_mm <= cfg_data[SPM_W-1:0];
				REG_PIERCE_OFS:   cfg_q.pierce_ofs   <= cfg_data[OFS_W-1:0];
				REG_SLIT_OFS:     cfg_q.slit_ofs     <= cfg_data[OFS_W-1:0];
				REG_CUT_OFS:      cfg_q.cut_ofs      <= cfg_data[OFS_W-1:0];
				REG_RECIPE0:      cfg_q.recipe0      <= cfg_data;
				REG_RECIPE1:      cfg_q.recipe1      <= cfg_data;
				REG_RECIPE2:      cfg_q.recipe2      <= cfg_data;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	eto_gen #(
		.WINDOW_BEFORE  (WINDOW_BEFORE),
		.WINDOW_AFTER   (WINDOW_AFTER),
		.RECIPE_SIZE    (RECIPE_SIZE),
		.EVENT_CAPACITY (EVENT_CAPACITY)
	) u_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept),
		.start_piece (start_piece),
		.cfg         (cfg_q),
		.evt         (evt),
		.idle        (gen_idle)
	);

	// result transfer shifts the chain toward the head
	assign out_valid      = (state_q == ST_DRAIN) && slot[1].valid;
	assign pop            = out_valid && !out_stall;
	assign position_steps = slot[1].key;
	assign pierce         = slot[1].flags[0];
	assign slit           = slot[1].flags[1];
	assign cut            = slot[1].flags[2];
	assign last           = !slot[2].valid;

	assign ctrl = '{ins: evt.valid, pop: pop, any_eq: |eq_vec, key: evt.key,
		flags: evt.flags};

	assign slot[0]                  = '0;
	assign slot[EVENT_CAPACITY + 1] = '0;

	for (genvar i = 0; i < EVENT_CAPACITY; i++) begin : g_cell
		logic prev_gt;
		if (i == 0) begin : g_head
			assign prev_gt = 1'b0;
		end else begin : g_body
			assign prev_gt = gt_vec[i-1];
		end
		eto_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.prev_gt   (prev_gt),
			.prev_slot (slot[i]),
			.next_slot (slot[i+2]),
			.slot      (slot[i+1]),
			.gt        (gt_vec[i]),
			.eq        (eq_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (gen_idle) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (pop && last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// testbench for event_timeline_sort_merge: predicts each merged event list and checks every transfer

module tb_top;
	import eto_pkg::*;

	localparam int WINDOW_BEFORE  = 5;
	localparam int WINDOW_AFTER   = 15;
	localparam int RECIPE_SIZE    = 3;
	localparam int EVENT_CAPACITY = 64;

	localparam logic [FLAG_W-1:0] TOOL_NONE   = 3'b000;
	localparam logic [FLAG_W-1:0] TOOL_PIERCE = 3'b001;
	localparam logic [FLAG_W-1:0] TOOL_SLIT   = 3'b010;
	localparam logic [FLAG_W-1:0] TOOL_CUT    = 3'b100;

	localparam longint HALF_STEP = 64'sd32768;
	localparam int FRAC_BITS = 16;
	localparam longint STEP_MAX = 64'sh0000_0000_FFFF_FFFF;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_REPORTS = 30;
	localparam longint RUN_LIMIT_NS = 64'd20_000_000;

	typedef enum int {CFG_RANDOM, CFG_DENSE, CFG_TYPICAL, CFG_EXTREME} cfg_style_e;

	typedef struct packed {
		logic [KEY_W-1:0] position_steps;
		logic pierce;
		logic slit;
		logic cut;
		logic last;
	} timeline_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [ENT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic [PIECE_W-1:0] start_piece = '0;
	logic out_stall = 1'b0;
	logic cfg_ready;
	logic in_stall;
	logic out_valid;
	logic [KEY_W-1:0] position_steps;
	logic pierce;
	logic slit;
	logic cut;
	logic last;

	eto_cfg_t cfg_shadow;
	timeline_event_t expected_events[$];
	timeline_event_t want;
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	event_timeline_sort_merge dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_piece(start_piece),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.position_steps(position_steps),
		.pierce(pierce),
		.slit(slit),
		.cut(cut),
		.last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	function automatic logic [ENT_W-1:0] recipe_word(input int ofs, input logic [FLAG_W-1:0] tools);
		return {ofs[ENT_W-FLAG_W-1:0], tools};
	endfunction

	// window of pieces, stable sort by step position, merge of equal positions
	function automatic void predict_timeline(input logic [PIECE_W-1:0] piece);
		logic [KEY_W-1:0] sorted_pos[$];
		logic [FLAG_W-1:0] sorted_tools[$];
		logic [KEY_W-1:0] merged_pos[$];
		logic [FLAG_W-1:0] merged_tools[$];
		logic [ENT_W-1:0] recipe[RECIPE_MAX];
		logic signed [OFS_W-1:0] tool_ofs;
		logic [FLAG_W-1:0] tools;
		logic [KEY_W-1:0] step_pos;
		longint first_piece, end_piece, pos_mm, prod, rounded;
		int slot, n_events;
		timeline_event_t ev;
		recipe[0] = cfg_shadow.recipe0;
		recipe[1] = cfg_shadow.recipe1;
		recipe[2] = cfg_shadow.recipe2;
		first_piece = (piece >= WINDOW_BEFORE) ? longint'(piece) - WINDOW_BEFORE : 0;
		end_piece = longint'(piece) + WINDOW_AFTER;
		n_events = 0;
		for (longint n = first_piece; n < end_piece; n++) begin
			for (int e = 0; e < RECIPE_SIZE; e++) begin
				if (n_events < EVENT_CAPACITY) begin
					tools = recipe[e][FLAG_W-1:0];
					if ((tools & TOOL_PIERCE) != TOOL_NONE) tool_ofs = cfg_shadow.pierce_ofs;
					else if ((tools & TOOL_SLIT) != TOOL_NONE) tool_ofs = cfg_shadow.slit_ofs;
					else if ((tools & TOOL_CUT) != TOOL_NONE) tool_ofs = cfg_shadow.cut_ofs;
					else tool_ofs = '0;
					pos_mm = n * longint'(cfg_shadow.piece_length) + longint'(tool_ofs)
						+ longint'(recipe[e][ENT_W-1:FLAG_W]);
					prod = pos_mm * longint'(cfg_shadow.steps_per_mm);
					rounded = (prod + HALF_STEP) >>> FRAC_BITS;
					if (prod < 0) step_pos = '0;
					else if (rounded > STEP_MAX) step_pos = '1;
					else step_pos = rounded[KEY_W-1:0];
					slot = sorted_pos.size();
					while (slot > 0 && sorted_pos[slot-1] > step_pos) slot--;
					sorted_pos.insert(slot, step_pos);
					sorted_tools.insert(slot, tools);
					n_events++;
				end
			end
		end
		for (int i = 0; i < sorted_pos.size(); i++) begin
			if (merged_pos.size() > 0 && merged_pos[merged_pos.size()-1] == sorted_pos[i]) begin
				merged_tools[merged_tools.size()-1] |= sorted_tools[i];
			end else begin
				merged_pos.push_back(sorted_pos[i]);
				merged_tools.push_back(sorted_tools[i]);
			end
		end
		for (int i = 0; i < merged_pos.size(); i++) begin
			ev.position_steps = merged_pos[i];
			ev.pierce = |(merged_tools[i] & TOOL_PIERCE);
			ev.slit = |(merged_tools[i] & TOOL_SLIT);
			ev.cut = |(merged_tools[i] & TOOL_CUT);
			ev.last = (i == merged_pos.size() - 1);
			expected_events.push_back(ev);
		end
	endfunction

	function automatic void check_field(input string name, input logic [KEY_W-1:0] exp_val,
			input logic [KEY_W-1:0] act_val);
		if (exp_val !== act_val) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_events.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: event transfer with none expected, actual position_steps %0d",
						$time, position_steps);
			end else begin
				want = expected_events.pop_front();
				check_field("position_steps", want.position_steps, position_steps);
				check_field("pierce", KEY_W'(want.pierce), KEY_W'(pierce));
				check_field("slit", KEY_W'(want.slit), KEY_W'(slit));
				check_field("cut", KEY_W'(want.cut), KEY_W'(cut));
				check_field("last", KEY_W'(want.last), KEY_W'(last));
			end
		end
	end

	task automatic write_reg(input eto_reg_e idx, input logic [ENT_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_PIECE_LENGTH: cfg_shadow.piece_length = data[LEN_W-1:0];
			REG_STEPS_PER_MM: cfg_shadow.steps_per_mm = data[SPM_W-1:0];
			REG_PIERCE_OFS:   cfg_shadow.pierce_ofs = data[OFS_W-1:0];
			REG_SLIT_OFS:     cfg_shadow.slit_ofs = data[OFS_W-1:0];
			REG_CUT_OFS:      cfg_shadow.cut_ofs = data[OFS_W-1:0];
			REG_RECIPE0:      cfg_shadow.recipe0 = data;
			REG_RECIPE1:      cfg_shadow.recipe1 = data;
			REG_RECIPE2:      cfg_shadow.recipe2 = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_piece(input logic [PIECE_W-1:0] piece);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		start_piece <= piece;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_timeline(piece);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic randomize_config();
		cfg_style_e style;
		eto_reg_e idx;
		logic [31:0] value;
		bit is_ofs;
		style = cfg_style_e'($urandom_range(0, 3));
		for (int r = REG_PIECE_LENGTH; r <= REG_RECIPE2; r++) begin
			idx = eto_reg_e'(r);
			is_ofs = idx inside {REG_PIERCE_OFS, REG_SLIT_OFS, REG_CUT_OFS};
			case (style)
				CFG_RANDOM: value = $urandom;
				CFG_DENSE: begin
					if (is_ofs) value = $urandom_range(0, 8) - 4;
					else if (idx == REG_STEPS_PER_MM) value = $urandom;
					else value = $urandom_range(0, 63);
				end
				CFG_TYPICAL: begin
					if (is_ofs) value = $urandom_range(0, 20000) - 10000;
					else if (idx == REG_PIECE_LENGTH) value = $urandom_range(0, 256000);
					else if (idx == REG_STEPS_PER_MM) value = $urandom_range(1, 4096);
					else value = 32'(recipe_word($urandom_range(0, 256000),
						FLAG_W'($urandom_range(0, 7))));
				end
				default: begin
					case ($urandom_range(0, 3))
						0: value = '0;
						1: value = '1;
						2: value = 32'd1 << (OFS_W - 1);
						default: value = (32'd1 << (OFS_W - 1)) - 1;
					endcase
				end
			endcase
			write_reg(idx, value[ENT_W-1:0]);
		end
	endtask

	task automatic test_reset_values();
		idle_pct = 0;
		stall_pct = 0;
		send_piece(16'd0);
		send_piece(16'd4);
		send_piece(16'd5);
		send_piece(16'hFFFF);
		drain();
	endtask

	// every flag combination picks its tool offset by priority
	task automatic test_tool_selection();
		idle_pct = 33;
		stall_pct = 33;
		write_reg(REG_PIECE_LENGTH, 23'd12800);
		write_reg(REG_STEPS_PER_MM, 23'd256);
		write_reg(REG_PIERCE_OFS, 23'd100);
		write_reg(REG_SLIT_OFS, -23'sd200);
		write_reg(REG_CUT_OFS, 23'd300);
		for (int base = 0; base < 8; base += 3) begin
			for (int e = 0; e < RECIPE_MAX; e++)
				write_reg(eto_reg_e'(REG_RECIPE0 + e),
					recipe_word(1000 * (e + 1), FLAG_W'((base + e) % 8)));
			send_piece(16'd10);
			drain();
		end
	endtask

	task automatic test_clamp_and_saturation();
		idle_pct = 0;
		stall_pct = 84;
		// negative positions clamp to zero
		write_reg(REG_PIECE_LENGTH, 23'd100);
		write_reg(REG_STEPS_PER_MM, ENT_W'({SPM_W{1'b1}}));
		write_reg(REG_PIERCE_OFS, 23'(32'd1 << (OFS_W - 1)));
		write_reg(REG_SLIT_OFS, 23'(32'd1 << (OFS_W - 1)));
		write_reg(REG_RECIPE0, recipe_word(0, TOOL_PIERCE));
		write_reg(REG_RECIPE1, recipe_word(5000, TOOL_SLIT));
		write_reg(REG_RECIPE2, recipe_word(0, TOOL_NONE));
		send_piece(16'd0);
		send_piece(16'd3);
		drain();
		// largest values saturate
		write_reg(REG_PIECE_LENGTH, ENT_W'({LEN_W{1'b1}}));
		write_reg(REG_PIERCE_OFS, 23'((32'd1 << (OFS_W - 1)) - 1));
		write_reg(REG_SLIT_OFS, 23'((32'd1 << (OFS_W - 1)) - 1));
		write_reg(REG_CUT_OFS, 23'((32'd1 << (OFS_W - 1)) - 1));
		write_reg(REG_RECIPE0, recipe_word((1 << LEN_W) - 1, TOOL_PIERCE | TOOL_SLIT | TOOL_CUT));
		write_reg(REG_RECIPE1, recipe_word((1 << LEN_W) - 1, TOOL_SLIT));
		write_reg(REG_RECIPE2, recipe_word((1 << LEN_W) - 1, TOOL_CUT));
		send_piece(16'hFFFF);
		send_piece(16'd0);
		drain();
	endtask

	task automatic test_position_merge();
		idle_pct = 84;
		stall_pct = 0;
		write_reg(REG_PIECE_LENGTH, 23'd0);
		write_reg(REG_STEPS_PER_MM, 23'd256);
		write_reg(REG_PIERCE_OFS, 23'd0);
		write_reg(REG_SLIT_OFS, 23'd0);
		write_reg(REG_CUT_OFS, 23'd0);
		write_reg(REG_RECIPE0, recipe_word(500, TOOL_PIERCE));
		write_reg(REG_RECIPE1, recipe_word(500, TOOL_SLIT));
		write_reg(REG_RECIPE2, recipe_word(500, TOOL_CUT));
		send_piece(16'd77);
		drain();
		write_reg(REG_PIECE_LENGTH, 23'd1000);
		write_reg(REG_STEPS_PER_MM, 23'd0);
		send_piece(16'd300);
		drain();
		// coarse scale rounds neighboring events onto the same step
		write_reg(REG_PIECE_LENGTH, 23'd8);
		write_reg(REG_STEPS_PER_MM, 23'd32);
		write_reg(REG_RECIPE0, recipe_word(0, TOOL_SLIT));
		write_reg(REG_RECIPE1, recipe_word(1, TOOL_NONE));
		write_reg(REG_RECIPE2, recipe_word(2, TOOL_PIERCE | TOOL_CUT));
		send_piece(16'd12345);
		drain();
	endtask

	task automatic test_drain_pause();
		idle_pct = 84;
		stall_pct = 84;
		randomize_config();
		for (int i = 0; i < 4; i++) begin
			send_piece(PIECE_W'($urandom_range(0, 65535)));
			drain();
		end
	endtask

	task automatic test_random_timeline(input int idle, input int stall);
		logic [PIECE_W-1:0] piece;
		idle_pct = idle;
		stall_pct = stall;
		for (int chunk = 0; chunk < 4; chunk++) begin
			randomize_config();
			for (int i = 0; i < 10; i++) begin
				case ($urandom_range(0, 7))
					0: piece = PIECE_W'($urandom_range(0, 7));
					1: piece = PIECE_W'($urandom_range(65520, 65535));
					default: piece = PIECE_W'($urandom_range(0, 65535));
				endcase
				send_piece(piece);
			end
			drain();
		end
	endtask

	initial begin
		#(RUN_LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

	initial begin
		cfg_shadow.piece_length = '0;
		cfg_shadow.steps_per_mm = SPM_RESET;
		cfg_shadow.pierce_ofs = '0;
		cfg_shadow.slit_ofs = '0;
		cfg_shadow.cut_ofs = '0;
		cfg_shadow.recipe0 = RECIPE0_RESET;
		cfg_shadow.recipe1 = RECIPE1_RESET;
		cfg_shadow.recipe2 = RECIPE2_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_tool_selection();
		test_clamp_and_saturation();
		test_position_merge();
		test_drain_pause();
		test_random_timeline(0, 0);
		test_random_timeline(84, 0);
		test_random_timeline(0, 84);
		test_random_timeline(33, 33);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
